// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/alsc_pkg.sv -----
package alsc_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_MODE           = 2'd0;
   localparam logic [1:0] CSR_START_KEY      = 2'd1;
   localparam logic [1:0] CSR_KEY_MULTIPLIER = 2'd2;
   localparam logic [1:0] CSR_KEY_ADDEND     = 2'd3;

   // register reset values
   localparam logic [15:0] RESET_START_KEY      = 16'd62153;
   localparam logic [15:0] RESET_KEY_MULTIPLIER = 16'd52845;
   localparam logic [15:0] RESET_KEY_ADDEND     = 16'd22719;

   // armor letters and the end-of-message suffix
   localparam logic [7:0] LETTER_A  = 8'd65;
   localparam logic [7:0] RADIX     = 8'd26;
   localparam logic [7:0] SUFFIX_P  = 8'd80;
   localparam logic [7:0] SUFFIX_C  = 8'd67;
   // (-65 * 27) mod 256, the letter offset folded into the pair rebuild
   localparam logic [7:0] PAIR_BIAS = 8'd37;

   // reciprocal of 26 scaled by 2^11, exact for all byte values
   localparam logic [6:0] RECIP_26  = 7'd79;
   localparam int         RECIP_SH  = 11;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   // key update on cipher byte c
   function automatic logic [15:0] advance_key(input logic [7:0] c,
                                               input logic [15:0] key,
                                               input logic [15:0] mult,
                                               input logic [15:0] addend);
      logic [15:0] t;
      logic [31:0] prod;
      t    = {8'd0, c} + key;
      prod = t * mult;
      return prod[15:0] + addend;
   endfunction

   // c / 26 for a byte
   function automatic logic [3:0] div26(input logic [7:0] c);
      logic [14:0] prod;
      prod = c * RECIP_26;
      return prod[RECIP_SH+3:RECIP_SH];
   endfunction

   // first armor letter of a cipher byte
   function automatic logic [7:0] letter_hi(input logic [7:0] c);
      return LETTER_A + {4'd0, div26(c)};
   endfunction

   // second armor letter of a cipher byte
   function automatic logic [7:0] letter_lo(input logic [7:0] c);
      logic [7:0] q26;
      q26 = {4'd0, div26(c)} * RADIX;
      return LETTER_A + (c - q26);
   endfunction

endpackage

// ----- hw/rtl/autokey_letter_stream_cipher_top.sv -----
// Autokey letter stream cipher, one pass. In encrypt mode every request byte
// leaves as two armor letters; a byte marked end of message also emits the
// enciphered 'P','C' suffix, each as two letters. In decrypt mode one letter
// is taken per cycle unless the slot is held, and gives at most one result.
// The single result register takes one result per cycle while the sink is
// ready and is fed by the cipher-byte slot. A new request is taken while the
// result register still waits on the sink. The user must write configuration
// only while the block is idle; the block does not enforce it. Writing mode
// aborts any message in progress and writing start_key reloads the key.
`include "assert_macros.svh"

module autokey_letter_stream_cipher_top
   import alsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_symbol,
   input  logic        req_end_of_message,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_no_data,
   output logic        rsp_last_out,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   mode_type    mode_ff;
   logic [15:0] start_key_ff;
   logic [15:0] key_mult_ff;
   logic [15:0] key_addend_ff;

   // message state
   logic [15:0] running_key_ff, running_key_in;
   logic [7:0]  held_letter_ff, held_letter_in;
   logic        letter_pending_ff, letter_pending_in;
   logic [7:0]  delay0_ff, delay0_in;
   logic [7:0]  delay1_ff, delay1_in;
   logic [1:0]  delay_fill_ff, delay_fill_in;

   // slot holding the byte being emitted
   logic        slot_valid_ff, slot_valid_in;
   logic        slot_enc_ff, slot_enc_in;
   logic [7:0]  slot_byte_ff, slot_byte_in;
   logic        slot_no_data_ff, slot_no_data_in;
   logic        slot_last_ff, slot_last_in;
   logic        slot_phase_ff, slot_phase_in;
   logic [1:0]  slot_suffix_ff, slot_suffix_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_no_data_ff, rsp_no_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        emit;
   logic        slot_final;
   logic        accept;
   logic [7:0]  enc_byte;
   logic [7:0]  pair_byte;
   logic [7:0]  plain_byte;
   logic [7:0]  suffix_byte;

   // slot hands a result to the result register
   assign emit       = slot_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign slot_final = !slot_enc_ff || (slot_phase_ff && (slot_suffix_ff == 2'd0));
   assign req_ready  = !slot_valid_ff || (emit && slot_final);
   assign accept     = req_valid && req_ready;

   // cipher arithmetic
   assign enc_byte    = req_symbol ^ running_key_ff[15:8];
   assign pair_byte   = held_letter_ff * RADIX + req_symbol + PAIR_BIAS;
   assign plain_byte  = pair_byte ^ running_key_ff[15:8];
   assign suffix_byte = ((slot_suffix_ff == 2'd2) ? SUFFIX_P : SUFFIX_C)
                        ^ running_key_ff[15:8];

   // next state of slot, key, pair and delay line
   always_comb begin
      running_key_in    = running_key_ff;
      held_letter_in    = held_letter_ff;
      letter_pending_in = letter_pending_ff;
      delay0_in         = delay0_ff;
      delay1_in         = delay1_ff;
      delay_fill_in     = delay_fill_ff;
      slot_valid_in     = slot_valid_ff;
      slot_enc_in       = slot_enc_ff;
      slot_byte_in      = slot_byte_ff;
      slot_no_data_in   = slot_no_data_ff;
      slot_last_in      = slot_last_ff;
      slot_phase_in     = slot_phase_ff;
      slot_suffix_in    = slot_suffix_ff;

      // slot progress on each emitted letter
      if (emit) begin
         if (slot_final) begin
            slot_valid_in = 1'b0;
         end else if (!slot_phase_ff) begin
            slot_phase_in = 1'b1;
         end else begin
            slot_byte_in   = suffix_byte;
            slot_phase_in  = 1'b0;
            slot_suffix_in = slot_suffix_ff - 2'd1;
            if (slot_suffix_ff == 2'd1) begin
               slot_last_in   = 1'b1;
               running_key_in = start_key_ff;
            end else begin
               running_key_in = advance_key(suffix_byte, running_key_ff,
                                            key_mult_ff, key_addend_ff);
            end
         end
      end

      // new request
      if (accept) begin
         if (mode_ff == MODE_ENCRYPT) begin
            running_key_in  = advance_key(enc_byte, running_key_ff,
                                          key_mult_ff, key_addend_ff);
            slot_valid_in   = 1'b1;
            slot_enc_in     = 1'b1;
            slot_byte_in    = enc_byte;
            slot_no_data_in = 1'b0;
            slot_last_in    = 1'b0;
            slot_phase_in   = 1'b0;
            slot_suffix_in  = req_end_of_message ? 2'd2 : 2'd0;
         end else begin
            slot_enc_in     = 1'b0;
            slot_phase_in   = 1'b0;
            slot_suffix_in  = 2'd0;
            slot_last_in    = req_end_of_message;
            slot_no_data_in = 1'b1;
            slot_byte_in    = 8'd0;
            slot_valid_in   = req_end_of_message;
            if (!letter_pending_ff) begin
               if (!req_end_of_message) begin
                  held_letter_in    = req_symbol;
                  letter_pending_in = 1'b1;
               end
            end else begin
               running_key_in    = advance_key(pair_byte, running_key_ff,
                                               key_mult_ff, key_addend_ff);
               letter_pending_in = 1'b0;
               held_letter_in    = 8'd0;
               if (delay_fill_ff[1]) begin
                  slot_valid_in   = 1'b1;
                  slot_no_data_in = 1'b0;
                  slot_byte_in    = delay0_ff;
                  delay0_in       = delay1_ff;
                  delay1_in       = plain_byte;
               end else begin
                  if (delay_fill_ff[0]) begin
                     delay1_in = plain_byte;
                  end else begin
                     delay0_in = plain_byte;
                  end
                  delay_fill_in = delay_fill_ff + 2'd1;
               end
            end
            // end of message clears the message state
            if (req_end_of_message) begin
               running_key_in    = start_key_ff;
               held_letter_in    = 8'd0;
               letter_pending_in = 1'b0;
               delay0_in         = 8'd0;
               delay1_in         = 8'd0;
               delay_fill_in     = 2'd0;
            end
         end
      end
   end

   // result register load
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_no_data_in = rsp_no_data_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_no_data_in = slot_no_data_ff;
         if (!slot_enc_ff) begin
            rsp_byte_in = slot_byte_ff;
            rsp_last_in = slot_last_ff;
         end else if (!slot_phase_ff) begin
            rsp_byte_in = letter_hi(slot_byte_ff);
            rsp_last_in = 1'b0;
         end else begin
            rsp_byte_in = letter_lo(slot_byte_ff);
            rsp_last_in = slot_last_ff;
         end
      end
   end

   // configuration registers and message state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_ENCRYPT;
         start_key_ff      <= RESET_START_KEY;
         key_mult_ff       <= RESET_KEY_MULTIPLIER;
         key_addend_ff     <= RESET_KEY_ADDEND;
         running_key_ff    <= RESET_START_KEY;
         held_letter_ff    <= 8'd0;
         letter_pending_ff <= 1'b0;
         delay0_ff         <= 8'd0;
         delay1_ff         <= 8'd0;
         delay_fill_ff     <= 2'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE: begin
               mode_ff           <= mode_type'(csr_write_data[0]);
               running_key_ff    <= start_key_ff;
               held_letter_ff    <= 8'd0;
               letter_pending_ff <= 1'b0;
               delay0_ff         <= 8'd0;
               delay1_ff         <= 8'd0;
               delay_fill_ff     <= 2'd0;
            end
            CSR_START_KEY: begin
               start_key_ff   <= csr_write_data;
               running_key_ff <= csr_write_data;
            end
            CSR_KEY_MULTIPLIER: begin
               key_mult_ff <= csr_write_data;
            end
            CSR_KEY_ADDEND: begin
               key_addend_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end else begin
         running_key_ff    <= running_key_in;
         held_letter_ff    <= held_letter_in;
         letter_pending_ff <= letter_pending_in;
         delay0_ff         <= delay0_in;
         delay1_ff         <= delay1_in;
         delay_fill_ff     <= delay_fill_in;
      end
   end

   // slot and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // slot and result payload
   always_ff @(posedge clock) begin
      slot_enc_ff     <= slot_enc_in;
      slot_byte_ff    <= slot_byte_in;
      slot_no_data_ff <= slot_no_data_in;
      slot_last_ff    <= slot_last_in;
      slot_phase_ff   <= slot_phase_in;
      slot_suffix_ff  <= slot_suffix_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_no_data_ff  <= rsp_no_data_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_no_data  = rsp_no_data_ff;
   assign rsp_last_out = rsp_last_ff;

   // an encrypt request always fills the slot
   `ASSERT_NEXT(a_enc_fills_slot, clock, reset, accept && (mode_ff == MODE_ENCRYPT), slot_valid_ff, "encrypt request did not fill slot")
   // an end marker result always closes the message
   `ASSERT_SAME(a_marker_is_last, clock, reset, rsp_valid_ff && rsp_no_data_ff, rsp_last_ff, "end marker without last")
   // suffix bytes still owed means the slot is not the last byte
   `ASSERT_SAME(a_suffix_not_last, clock, reset, slot_valid_ff && (slot_suffix_ff != 2'd0), !slot_last_ff && slot_enc_ff, "suffix pending on last byte")
   // delay line never holds more than two bytes
   `ASSERT_SAME(a_fill_bound, clock, reset, delay_fill_ff[1], !delay_fill_ff[0], "delay fill overflow")

endmodule
